>>> hw/rtl/hhlp_pkg.sv
package hhlp_pkg;

    localparam int NAME_LEN_DFLT = 64;

    // width used to compare line positions against fixed lengths
    localparam int CW = 9;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_BACKEND  = 2'd2;

    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0] INTERVAL_RST = 16'd500;
    localparam logic        BACKEND_RST  = 1'b0;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] REPLY_NONE   = 2'd0;
    localparam logic [1:0] REPLY_ACK    = 2'd1;
    localparam logic [1:0] REPLY_NAK    = 2'd2;
    localparam logic [1:0] REPLY_PROMPT = 2'd3;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic       BACKEND_MAV  = 1'b0;
    localparam logic       BACKEND_UROS = 1'b1;

    localparam logic [7:0] WORD_UROS [16] = '{
        "B", "A", "C", "K", "E", "N", "D", ":", "m", "i", "c", "r", "o", "r", "o", "s"
    };
    localparam logic [7:0] WORD_MAV [15] = '{
        "B", "A", "C", "K", "E", "N", "D", ":", "m", "a", "v", "l", "i", "n", "k"
    };
    localparam logic [7:0] WORD_NS [3]  = '{"N", "S", ":"};
    localparam logic [7:0] WORD_END [3] = '{"E", "N", "D"};

    localparam logic [CW-1:0] LEN_PREFIX_BK = 9'd8;
    localparam logic [CW-1:0] LEN_MAV       = 9'd15;
    localparam logic [CW-1:0] LEN_UROS      = 9'd16;
    localparam logic [CW-1:0] LEN_SHORT     = 9'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic [5:0] char_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] reply;
        logic       finished;
        logic       name_received;
        logic       backend_choice;
        logic [7:0] namespace_char;
    } t_result;

    typedef enum logic [2:0] {
        OP_START,
        OP_BYTE,
        OP_EOL,
        OP_SKIP,
        OP_TICK,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] byte_value;
        logic [5:0] char_index;
    } t_op_item;

    typedef struct packed {
        logic [15:0] timeout;
        logic [15:0] interval;
        logic        default_backend;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACTIVE,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_COPY,
        B_READ,
        B_RESP
    } t_bstate;

endpackage

>>> hw/rtl/hhlp_ram.sv
module hhlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/hhlp_front.sv
module hhlp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  hhlp_pkg::t_in_item i_item,
    output logic              o_vld,
    output hhlp_pkg::t_op_item o_item,
    input  logic              i_pop
);

    import hhlp_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CNW = $clog2(Q_DEPTH + 1);

    t_op_item        w_dec;
    t_op_item        r_slot [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNW-1:0]  r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CNW-1:0]  n_count;
    logic            w_wr;
    logic            w_rd;

    // classify the command before it is queued
    always_comb begin
        w_dec.byte_value = i_item.byte_value;
        w_dec.char_index = i_item.char_index;
        unique case (i_item.command)
            CMD_START: w_dec.op = OP_START;
            CMD_BYTE: begin
                if (i_item.byte_value == CHAR_LF) begin
                    w_dec.op = OP_EOL;
                end else if (i_item.byte_value == CHAR_CR) begin
                    w_dec.op = OP_SKIP;
                end else begin
                    w_dec.op = OP_BYTE;
                end
            end
            CMD_TICK: w_dec.op = OP_TICK;
            CMD_READ: w_dec.op = OP_READ;
            default:  w_dec.op = OP_READ;
        endcase
    end

    assign o_full = (r_count == CNW'(Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_item = r_slot[r_rd_ptr];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_pop && o_vld;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= w_dec;
        end
    end

endmodule

>>> hw/rtl/hhlp_back.sv
module hhlp_back #(
    parameter int NAME_LEN = hhlp_pkg::NAME_LEN_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_vld,
    input  hhlp_pkg::t_op_item i_q_item,
    output logic               o_q_pop,
    input  hhlp_pkg::t_cfg     i_cfg,
    input  logic               i_bk_load,
    input  logic               i_pop,
    output logic               o_empty,
    output hhlp_pkg::t_result  o_result
);

    import hhlp_pkg::*;

    localparam int LW  = $clog2(NAME_LEN);
    localparam int LAW = $clog2(NAME_LEN - 1);

    t_bstate             r_state, n_state;
    t_phase              r_phase, n_phase;
    t_op                 r_op, n_op;
    logic [7:0]          r_byte, n_byte;
    logic [5:0]          r_idx, n_idx;
    logic [1:0]          r_reply, n_reply;
    logic [LW-1:0]       r_line_len, n_line_len;
    logic                r_f_bk, n_f_bk;
    logic                r_f_mav, n_f_mav;
    logic                r_f_uros, n_f_uros;
    logic                r_f_ns, n_f_ns;
    logic                r_f_end, n_f_end;
    logic                r_name_seen, n_name_seen;
    logic                r_backend, n_backend;
    logic [15:0]         r_elapsed, n_elapsed;
    logic [15:0]         r_since, n_since;
    logic [NAME_LEN-1:0] r_name_vld, n_name_vld;
    logic [LW-1:0]       r_cp_ptr, n_cp_ptr;
    logic [LW-1:0]       r_cp_end, n_cp_end;
    logic                r_cp_pend, n_cp_pend;
    logic [LW-1:0]       r_cp_waddr, n_cp_waddr;
    logic                r_cp_zero, n_cp_zero;
    logic                r_rd_inrng, n_rd_inrng;
    logic                r_rd_vld, n_rd_vld;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;

    logic                w_line_we;
    logic [LAW-1:0]      w_line_waddr;
    logic                w_line_re;
    logic [LAW-1:0]      w_line_raddr;
    logic [7:0]          w_line_rdata;
    logic                w_name_we;
    logic                w_name_re;
    logic [7:0]          w_name_rdata;
    logic                w_load_out;
    logic [CW-1:0]       w_l9;
    logic [CW-1:0]       w_idx9;
    logic                w_active;

    hhlp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_LEN - 1)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_line_we),
        .i_wr_addr (w_line_waddr),
        .i_wr_data (r_byte),
        .i_rd_en   (w_line_re),
        .i_rd_addr (w_line_raddr),
        .o_rd_data (w_line_rdata)
    );

    hhlp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_LEN)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_name_we),
        .i_wr_addr (r_cp_waddr),
        .i_wr_data (w_line_rdata),
        .i_rd_en   (w_name_re),
        .i_rd_addr (w_idx9[LW-1:0]),
        .o_rd_data (w_name_rdata)
    );

    assign w_l9     = CW'(r_line_len);
    assign w_idx9   = CW'(r_idx);
    assign w_active = (r_phase == PH_ACTIVE);
    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_byte      = r_byte;
        n_idx       = r_idx;
        n_reply     = r_reply;
        n_line_len  = r_line_len;
        n_f_bk      = r_f_bk;
        n_f_mav     = r_f_mav;
        n_f_uros    = r_f_uros;
        n_f_ns      = r_f_ns;
        n_f_end     = r_f_end;
        n_name_seen = r_name_seen;
        n_backend   = r_backend;
        n_elapsed   = r_elapsed;
        n_since     = r_since;
        n_name_vld  = r_name_vld;
        n_cp_ptr    = r_cp_ptr;
        n_cp_end    = r_cp_end;
        n_cp_pend   = r_cp_pend;
        n_cp_waddr  = r_cp_waddr;
        n_cp_zero   = r_cp_zero;
        n_rd_inrng  = r_rd_inrng;
        n_rd_vld    = r_rd_vld;
        o_q_pop      = 1'b0;
        w_line_we    = 1'b0;
        w_line_waddr = r_line_len[LAW-1:0];
        w_line_re    = 1'b0;
        w_line_raddr = r_cp_ptr[LAW-1:0];
        w_name_we    = 1'b0;
        w_name_re    = 1'b0;
        w_load_out   = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_item.op;
                    n_byte  = i_q_item.byte_value;
                    n_idx   = i_q_item.char_index;
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                n_reply = REPLY_NONE;
                n_state = B_READ;
                unique case (r_op)
                    OP_START: begin
                        if (r_phase == PH_IDLE) begin
                            n_line_len  = '0;
                            n_f_bk      = 1'b1;
                            n_f_mav     = 1'b1;
                            n_f_uros    = 1'b1;
                            n_f_ns      = 1'b1;
                            n_f_end     = 1'b1;
                            n_elapsed   = '0;
                            n_since     = '0;
                            n_name_seen = 1'b0;
                            n_reply     = REPLY_PROMPT;
                            n_phase     = (i_cfg.timeout == '0) ? PH_DONE : PH_ACTIVE;
                        end
                    end
                    OP_BYTE: begin
                        if (w_active && (w_l9 < CW'(NAME_LEN - 1))) begin
                            w_line_we  = 1'b1;
                            n_line_len = r_line_len + 1'b1;
                            if (w_l9 < LEN_PREFIX_BK) begin
                                n_f_bk = r_f_bk && (r_byte == WORD_UROS[w_l9[3:0]]);
                            end
                            if (w_l9 < LEN_MAV) begin
                                n_f_mav = r_f_mav && (r_byte == WORD_MAV[w_l9[3:0]]);
                            end
                            if (w_l9 < LEN_UROS) begin
                                n_f_uros = r_f_uros && (r_byte == WORD_UROS[w_l9[3:0]]);
                            end
                            if (w_l9 < LEN_SHORT) begin
                                n_f_ns  = r_f_ns && (r_byte == WORD_NS[w_l9[1:0]]);
                                n_f_end = r_f_end && (r_byte == WORD_END[w_l9[1:0]]);
                            end
                        end
                    end
                    OP_EOL: begin
                        if (w_active) begin
                            priority if (r_f_bk && (w_l9 >= LEN_PREFIX_BK)) begin
                                if (r_f_mav && (w_l9 == LEN_MAV)) begin
                                    n_backend = BACKEND_MAV;
                                    n_reply   = REPLY_ACK;
                                end else if (r_f_uros && (w_l9 == LEN_UROS)) begin
                                    n_backend = BACKEND_UROS;
                                    n_reply   = REPLY_ACK;
                                end else begin
                                    n_reply   = REPLY_NAK;
                                end
                            end else if (r_f_ns && (w_l9 >= LEN_SHORT)) begin
                                n_name_vld  = '0;
                                n_name_seen = 1'b1;
                                n_reply     = REPLY_ACK;
                                n_cp_ptr    = LW'(3);
                                n_cp_end    = r_line_len;
                                n_cp_pend   = 1'b0;
                                n_cp_zero   = 1'b0;
                                n_state     = B_COPY;
                            end else if (r_f_end && (w_l9 == LEN_SHORT)) begin
                                n_phase = PH_DONE;
                                n_reply = REPLY_ACK;
                            end else begin
                                n_reply = REPLY_NONE;
                            end
                            n_line_len = '0;
                            n_f_bk     = 1'b1;
                            n_f_mav    = 1'b1;
                            n_f_uros   = 1'b1;
                            n_f_ns     = 1'b1;
                            n_f_end    = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (w_active) begin
                            n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
                            n_since   = (r_since == '1) ? r_since : r_since + 1'b1;
                            if (n_elapsed >= i_cfg.timeout) begin
                                n_phase = PH_DONE;
                            end else if (n_since >= i_cfg.interval) begin
                                n_since = '0;
                                n_reply = REPLY_PROMPT;
                            end
                        end
                    end
                    OP_SKIP, OP_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
            B_COPY: begin
                // line bytes after the prefix, one per cycle, stop at a zero byte
                n_cp_pend = 1'b0;
                if (r_cp_ptr < r_cp_end) begin
                    w_line_re  = 1'b1;
                    n_cp_ptr   = r_cp_ptr + 1'b1;
                    n_cp_pend  = 1'b1;
                    n_cp_waddr = r_cp_ptr - LW'(3);
                end
                if (r_cp_pend) begin
                    if (!r_cp_zero && (w_line_rdata != 8'h00)) begin
                        w_name_we              = 1'b1;
                        n_name_vld[r_cp_waddr] = 1'b1;
                    end else begin
                        n_cp_zero = 1'b1;
                    end
                end
                if ((r_cp_ptr >= r_cp_end) && !r_cp_pend) begin
                    n_state = B_READ;
                end
            end
            B_READ: begin
                w_name_re  = 1'b1;
                n_rd_inrng = (w_idx9 < CW'(NAME_LEN));
                n_rd_vld   = n_rd_inrng && r_name_vld[w_idx9[LW-1:0]];
                n_state    = B_RESP;
            end
            B_RESP: begin
                if (!r_out_vld || i_pop) begin
                    w_load_out = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        if (i_bk_load && (r_phase == PH_IDLE)) begin
            n_backend = i_cfg.default_backend;
        end

        n_out.reply          = r_reply;
        n_out.finished       = (r_phase == PH_DONE);
        n_out.name_received  = r_name_seen;
        n_out.backend_choice = r_backend;
        n_out.namespace_char = (r_rd_inrng && r_rd_vld) ? w_name_rdata : 8'h00;

        if (w_load_out) begin
            n_out_vld = 1'b1;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_phase     <= PH_IDLE;
            r_line_len  <= '0;
            r_f_bk      <= 1'b1;
            r_f_mav     <= 1'b1;
            r_f_uros    <= 1'b1;
            r_f_ns      <= 1'b1;
            r_f_end     <= 1'b1;
            r_name_seen <= 1'b0;
            r_backend   <= BACKEND_RST;
            r_elapsed   <= '0;
            r_since     <= '0;
            r_name_vld  <= '0;
            r_cp_ptr    <= '0;
            r_cp_end    <= '0;
            r_cp_pend   <= 1'b0;
            r_cp_zero   <= 1'b0;
            r_rd_inrng  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_line_len  <= n_line_len;
            r_f_bk      <= n_f_bk;
            r_f_mav     <= n_f_mav;
            r_f_uros    <= n_f_uros;
            r_f_ns      <= n_f_ns;
            r_f_end     <= n_f_end;
            r_name_seen <= n_name_seen;
            r_backend   <= n_backend;
            r_elapsed   <= n_elapsed;
            r_since     <= n_since;
            r_name_vld  <= n_name_vld;
            r_cp_ptr    <= n_cp_ptr;
            r_cp_end    <= n_cp_end;
            r_cp_pend   <= n_cp_pend;
            r_cp_zero   <= n_cp_zero;
            r_rd_inrng  <= n_rd_inrng;
            r_rd_vld    <= n_rd_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_byte     <= n_byte;
        r_idx      <= n_idx;
        r_reply    <= n_reply;
        r_cp_waddr <= n_cp_waddr;
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/host_handshake_line_parser.sv
// host handshake line parser
// input channel: push/full carries one item (command, byte_value, char_index);
// a transfer happens on a clock edge with push high and full low.
// result channel: empty/pop; while empty is low o_result holds the oldest
// result, and a transfer happens on a clock edge with pop high and empty low.
// every accepted item gives exactly one result, in order.
// a two-entry queue after the command decoder lets items be taken while the
// executor works or while a result waits to be popped.
// the executor takes one item at a time from the queue and passes it through
// its exec, read and response states, then loads the result register; for a
// namespace line a copy state between exec and read moves the bytes after
// "NS:" from the line buffer into the namespace buffer by registered reads.
// if pop stays low the executor holds its finished result and the queue fills,
// then full rises.
// reset: registers return to 1000 ms timeout, 500 ms interval, mavlink; the
// handshake waits for a start item and the namespace reads as all zero.
// configuration registers over the apb port, 4-byte stride, are to be written
// only while idle by the user; the block itself does not enforce this.
module host_handshake_line_parser #(
    parameter int NAME_LEN = hhlp_pkg::NAME_LEN_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  hhlp_pkg::t_in_item          i_item,
    output logic                        empty,
    input  logic                        pop,
    output hhlp_pkg::t_result           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hhlp_pkg::ADDR_W-1:0] paddr,
    input  logic [hhlp_pkg::DATA_W-1:0] pwdata,
    output logic [hhlp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    import hhlp_pkg::*;

    logic [15:0] r_timeout;
    logic [15:0] r_interval;
    logic        r_dflt_bk;
    logic [15:0] n_timeout;
    logic [15:0] n_interval;
    logic        n_dflt_bk;
    logic        w_cfg_wr;
    logic        w_bk_load;
    logic [1:0]  w_reg_idx;
    t_cfg        w_cfg;
    logic        w_q_vld;
    logic        w_q_pop;
    t_op_item    w_q_item;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[3:2];

    always_comb begin
        n_timeout  = r_timeout;
        n_interval = r_interval;
        n_dflt_bk  = r_dflt_bk;
        w_bk_load  = 1'b0;
        prdata     = '0;
        unique case (w_reg_idx)
            REG_TIMEOUT: begin
                prdata = DATA_W'(r_timeout);
                if (w_cfg_wr) begin
                    n_timeout = pwdata[15:0];
                end
            end
            REG_INTERVAL: begin
                prdata = DATA_W'(r_interval);
                if (w_cfg_wr) begin
                    n_interval = pwdata[15:0];
                end
            end
            REG_BACKEND: begin
                prdata = DATA_W'(r_dflt_bk);
                if (w_cfg_wr) begin
                    n_dflt_bk = pwdata[0];
                    w_bk_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_interval <= INTERVAL_RST;
            r_dflt_bk  <= BACKEND_RST;
        end else begin
            r_timeout  <= n_timeout;
            r_interval <= n_interval;
            r_dflt_bk  <= n_dflt_bk;
        end
    end

    // backend load uses the value being written, not the old register
    assign w_cfg.timeout         = r_timeout;
    assign w_cfg.interval        = r_interval;
    assign w_cfg.default_backend = w_bk_load ? n_dflt_bk : r_dflt_bk;

    hhlp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    hhlp_back #(
        .NAME_LEN (NAME_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (w_q_vld),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_cfg     (w_cfg),
        .i_bk_load (w_bk_load),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hhlp_pkg::*;

    localparam int NAME_CHARS = NAME_LEN_DFLT;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_item i_item = '0;
    logic empty;
    logic pop = 1'b0;
    t_result o_result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    host_handshake_line_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // predicted parser state
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_interval;
    logic        cfg_default;
    logic [7:0]  line_buf [0:NAME_CHARS-2];
    int          line_len;
    logic [7:0]  name_buf [0:NAME_CHARS-1];
    logic        name_flag;
    logic        backend_cur;
    int          elapsed_ms;
    int          since_prompt_ms;
    t_phase      hs_phase;

    t_in_item pending_items [$];
    t_result  due_results [$];
    logic [7:0] line_bytes [$];
    int queued_count = 0;
    int accepted_count = 0;
    int results_seen = 0;
    int fault_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int take_gap = 0;
    bit steady = 1'b0;
    t_result next_due;

    function automatic logic line_has(int at, string w);
        if (at + w.len() > line_len) return 1'b0;
        for (int i = 0; i < w.len(); i++) begin
            if (line_buf[at + i] != w[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] close_line();
        logic [1:0] answer;
        answer = REPLY_NONE;
        if (line_has(0, "BACKEND:")) begin
            if (line_len == 15 && line_has(8, "mavlink")) begin
                backend_cur = BACKEND_MAV;
                answer = REPLY_ACK;
            end else if (line_len == 16 && line_has(8, "microros")) begin
                backend_cur = BACKEND_UROS;
                answer = REPLY_ACK;
            end else begin
                answer = REPLY_NAK;
            end
        end else if (line_has(0, "NS:")) begin
            for (int i = 0; i < NAME_CHARS; i++) name_buf[i] = 8'h00;
            for (int i = 3; i < line_len && i - 3 < NAME_CHARS - 1; i++) begin
                if (line_buf[i] == 8'h00) break;
                name_buf[i - 3] = line_buf[i];
            end
            name_flag = 1'b1;
            answer = REPLY_ACK;
        end else if (line_len == 3 && line_has(0, "END")) begin
            hs_phase = PH_DONE;
            answer = REPLY_ACK;
        end
        line_len = 0;
        for (int i = 0; i < NAME_CHARS - 1; i++) line_buf[i] = 8'h00;
        return answer;
    endfunction

    function automatic t_result handshake_step(t_in_item it);
        t_result r;
        r.reply = REPLY_NONE;
        case (it.command)
            CMD_START: begin
                if (hs_phase == PH_IDLE) begin
                    line_len = 0;
                    for (int i = 0; i < NAME_CHARS - 1; i++) line_buf[i] = 8'h00;
                    elapsed_ms = 0;
                    since_prompt_ms = 0;
                    name_flag = 1'b0;
                    r.reply = REPLY_PROMPT;
                    hs_phase = (cfg_timeout == 16'd0) ? PH_DONE : PH_ACTIVE;
                end
            end
            CMD_BYTE: begin
                if (hs_phase == PH_ACTIVE) begin
                    if (it.byte_value == CHAR_LF) begin
                        r.reply = close_line();
                    end else if (it.byte_value != CHAR_CR && line_len < NAME_CHARS - 1) begin
                        line_buf[line_len] = it.byte_value;
                        line_len++;
                    end
                end
            end
            CMD_TICK: begin
                if (hs_phase == PH_ACTIVE) begin
                    if (elapsed_ms < 65535) elapsed_ms++;
                    if (since_prompt_ms < 65535) since_prompt_ms++;
                    if (elapsed_ms >= int'(cfg_timeout)) begin
                        hs_phase = PH_DONE;
                    end else if (since_prompt_ms >= int'(cfg_interval)) begin
                        since_prompt_ms = 0;
                        r.reply = REPLY_PROMPT;
                    end
                end
            end
            default: ;
        endcase
        r.finished = (hs_phase == PH_DONE);
        r.name_received = name_flag;
        r.backend_choice = backend_cur;
        r.namespace_char = name_buf[it.char_index];
        return r;
    endfunction

    task automatic log_fault(string what, t_result want, t_result got);
        if (fault_count < 10) begin
            $display("result %0d %s: expected reply %0d fin %0d ns %0d be %0d char %02h,",
                     results_seen, what, want.reply, want.finished, want.name_received,
                     want.backend_choice, want.namespace_char);
            $display("    got reply %0d fin %0d ns %0d be %0d char %02h",
                     got.reply, got.finished, got.name_received, got.backend_choice,
                     got.namespace_char);
        end
        fault_count++;
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else begin
            if (push && !full) begin
                due_results.push_back(handshake_step(i_item));
                accepted_count++;
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (!steady && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    push <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_item <= pending_items.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            take_gap = 0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    log_fault("unexpected", '0, o_result);
                end else begin
                    next_due = due_results.pop_front();
                    if (o_result !== next_due) log_fault("mismatch", next_due, o_result);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                pop <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic add_command(logic [1:0] cmd, logic [7:0] b, logic [5:0] idx);
        t_in_item it;
        it.command = cmd;
        it.byte_value = b;
        it.char_index = idx;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    task automatic add_junk(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            line_bytes.push_back((b == CHAR_LF) ? 8'h00 : b);
        end
    endtask

    task automatic add_name(int n);
        for (int i = 0; i < n; i++) line_bytes.push_back(8'($urandom_range(33, 126)));
    endtask

    // line bytes with stray carriage returns, then the newline
    task automatic add_line();
        for (int i = 0; i < line_bytes.size(); i++) begin
            if ($urandom_range(0, 15) == 0) begin
                add_command(CMD_BYTE, CHAR_CR, 6'($urandom_range(0, 63)));
            end
            add_command(CMD_BYTE, line_bytes[i], 6'($urandom_range(0, 63)));
        end
        add_command(CMD_BYTE, CHAR_LF, 6'($urandom_range(0, 63)));
        line_bytes.delete();
    endtask

    task automatic add_random_mix();
        int kind;
        int n;
        int pick;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                add_text("BACKEND:");
                pick = $urandom_range(0, 5);
                case (pick)
                    0: add_text("mavlink");
                    1: add_text("microros");
                    2: add_text("mavlin");
                    3: add_text("microrosx");
                    4: add_junk($urandom_range(0, 10));
                    default: begin
                        add_text("mavlink");
                        line_bytes.push_back(8'h00);
                    end
                endcase
                add_line();
            end
            2, 3: begin
                add_text("NS:");
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) add_junk(n);
                else add_name(n);
                if (n > 0 && $urandom_range(0, 7) == 0) begin
                    line_bytes[$urandom_range(3, line_bytes.size() - 1)] = 8'h00;
                end
                add_line();
            end
            4: begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0: add_text("END ");
                    1: add_text("EN");
                    2: add_text("ENDEND");
                    3: add_text("end");
                    4: add_text("xEND");
                    5: add_text("NS");
                    6: add_text("BACKEND");
                    default: ;
                endcase
                add_line();
            end
            5: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    add_command(CMD_BYTE, 8'($urandom_range(0, 255)),
                                6'($urandom_range(0, 63)));
                end
            end
            6, 7: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    add_command(CMD_TICK, 8'($urandom_range(0, 255)),
                                6'($urandom_range(0, 63)));
                end
            end
            8: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    add_command(CMD_READ, 8'($urandom_range(0, 255)),
                                6'($urandom_range(0, 63)));
                end
            end
            default: begin
                pick = $urandom_range(0, 2);
                case (pick)
                    0: add_command(CMD_START, 8'($urandom_range(0, 255)),
                                   6'($urandom_range(0, 63)));
                    1: add_command(CMD_BYTE, CHAR_LF, 6'($urandom_range(0, 63)));
                    default: add_command(CMD_BYTE, CHAR_CR, 6'($urandom_range(0, 63)));
                endcase
            end
        endcase
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg_timeout = value[15:0];
            REG_INTERVAL: cfg_interval = value[15:0];
            REG_BACKEND: begin
                cfg_default = value[0];
                if (hs_phase == PH_IDLE) backend_cur = cfg_default;
            end
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (accepted_count != queued_count || due_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int stop_at;
        int pick;
        int span;
        cfg_timeout = TIMEOUT_RST;
        cfg_interval = INTERVAL_RST;
        cfg_default = BACKEND_RST;
        for (int i = 0; i < NAME_CHARS - 1; i++) line_buf[i] = 8'h00;
        for (int i = 0; i < NAME_CHARS; i++) name_buf[i] = 8'h00;
        line_len = 0;
        name_flag = 1'b0;
        backend_cur = BACKEND_RST;
        elapsed_ms = 0;
        since_prompt_ms = 0;
        hs_phase = PH_IDLE;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_BACKEND, 32'd1);
        write_reg(REG_UNUSED, $urandom);

        // everything before start is ignored except reads
        add_command(CMD_BYTE, 8'hFF, 6'd63);
        add_command(CMD_BYTE, 8'h00, 6'd0);
        add_text("END");
        add_line();
        add_command(CMD_TICK, 8'hFF, 6'd63);
        add_command(CMD_READ, 8'h00, 6'd63);
        add_command(CMD_READ, 8'hFF, 6'd0);
        wait_drained();

        write_reg(REG_TIMEOUT, {16'($urandom), 16'hFFFF});
        write_reg(REG_INTERVAL, $urandom_range(2, 30));
        write_reg(REG_BACKEND, $urandom);
        add_command(CMD_START, 8'h00, 6'd0);
        add_command(CMD_START, 8'hFF, 6'd63);
        add_command(CMD_TICK, 8'h00, 6'd0);
        add_command(CMD_READ, 8'h00, 6'd63);

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: write_reg(REG_INTERVAL, 32'd0);
                    2: write_reg(REG_INTERVAL, 32'hFFFF);
                    default: write_reg(REG_INTERVAL, 32'd1);
                endcase
                write_reg(REG_TIMEOUT, $urandom_range(elapsed_ms + 4000, 65535));
                write_reg(REG_BACKEND, $urandom);
            end
            if (p == 3) steady = 1'b1;
            stop_at = queued_count + ((p == 3) ? 200 : 600);
            while (queued_count < stop_at) add_random_mix();
        end

        // close the handshake by END, by reaching the timeout, or by a zero timeout
        wait_drained();
        pick = $urandom_range(0, 2);
        case (pick)
            0: begin
                add_line();
                add_text("END");
                add_line();
            end
            1: begin
                span = $urandom_range(1, 6);
                write_reg(REG_INTERVAL, since_prompt_ms + span);
                write_reg(REG_TIMEOUT, elapsed_ms + span);
                for (int i = 0; i < 8; i++) begin
                    add_command(CMD_TICK, 8'($urandom_range(0, 255)), 6'(i));
                end
            end
            default: begin
                write_reg(REG_TIMEOUT, 32'd0);
                for (int i = 0; i < 3; i++) begin
                    add_command(CMD_TICK, 8'($urandom_range(0, 255)), 6'(i));
                end
            end
        endcase
        wait_drained();

        write_reg(REG_BACKEND, {31'd0, ~backend_cur});
        for (int i = 0; i < 60; i++) begin
            add_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        6'($urandom_range(0, 63)));
        end
        add_text("NS:late");
        add_line();
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (fault_count == 0 && due_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/hhlp_pkg.sv
hw/rtl/hhlp_ram.sv
hw/rtl/hhlp_front.sv
hw/rtl/hhlp_back.sv
hw/rtl/host_handshake_line_parser.sv
test/testbench.sv
